FILE: rtl/wall_crossing_loss_accumulator_top_defines.svh
// Assertion macros shared by the wall crossing loss accumulator RTL.
`ifndef WALL_CROSSING_LOSS_ACCUMULATOR_TOP_DEFINES_SVH
`define WALL_CROSSING_LOSS_ACCUMULATOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define WCLA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("wcla assertion failed");
`define WCLA_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  `WCLA_ASSERT(lbl, clk, rst_n, !(cond))
`else
`define WCLA_ASSERT(lbl, clk, rst_n, prop)
`define WCLA_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

FILE: rtl/wcla_pkg.sv
// Types and constants of the wall crossing loss accumulator.
`timescale 1ns / 1ps
package wcla_pkg;

  localparam int COORD_BITS = 16;
  localparam int LOSS_BITS  = 16;
  localparam int SUM_BITS   = 24;
  localparam int TOTAL_BITS = 24;
  // endpoint differences, products, and sums of two products
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = DIFF_BITS + COORD_BITS;
  localparam int ACC_BITS   = PROD_BITS + 1;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] ray_x;
    logic signed [COORD_BITS-1:0] ray_y;
    logic signed [COORD_BITS-1:0] ray_dx;
    logic signed [COORD_BITS-1:0] ray_dy;
    logic signed [COORD_BITS-1:0] wall_x;
    logic signed [COORD_BITS-1:0] wall_y;
    logic signed [COORD_BITS-1:0] wall_dx;
    logic signed [COORD_BITS-1:0] wall_dy;
    logic        [LOSS_BITS-1:0]  wall_loss;
    logic                         touches_endpoint;
    logic                         last_wall;
  } wcla_in_t;

  typedef struct packed {
    logic [TOTAL_BITS-1:0] total_loss;
    logic                  saturated;
  } wcla_out_t;

  // classified wall, handed from the front to the back
  typedef struct packed {
    logic                 crossed;
    logic [LOSS_BITS-1:0] loss;
    logic                 last;
  } wcla_entry_t;

endpackage

FILE: rtl/wcla_front.sv
// Front pipeline: intersection products, sign and magnitude tests, credit flow control.
`timescale 1ns / 1ps
module wcla_front #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  wcla_pkg::wcla_in_t item_i,
  input  logic               credit_ret_i,
  output logic               entry_valid_o,
  output wcla_pkg::wcla_entry_t entry_o
);
  import wcla_pkg::*;

  localparam int CRED_W = $clog2(QUEUE_DEPTH + 1);

  logic [CRED_W-1:0] credit_q, credit_d;
  logic              accept;

  // stage 1: endpoint differences
  logic                        s1_valid_q;
  logic signed [COORD_BITS-1:0] s1_rdx_q, s1_rdy_q, s1_wdx_q, s1_wdy_q;
  logic signed [DIFF_BITS-1:0]  s1_ex_q, s1_ey_q;
  wcla_entry_t                  s1_info_q;

  // stage 2: products
  logic                        s2_valid_q;
  logic signed [PROD_BITS-1:0] s2_z1_q, s2_z2_q, s2_r1_q, s2_r2_q, s2_t1_q, s2_t2_q;
  wcla_entry_t                 s2_info_q;

  // stage 3: cross product and both numerators
  logic                       s3_valid_q;
  logic signed [ACC_BITS-1:0] s3_z_q, s3_nr_q, s3_nt_q;
  wcla_entry_t                s3_info_q;

  // stage 4: signs, nonzero flags, magnitudes
  logic                s4_valid_q;
  logic                s4_z_neg_q, s4_r_neg_q, s4_t_neg_q;
  logic                s4_z_nz_q, s4_r_nz_q, s4_t_nz_q;
  logic [ACC_BITS-1:0] s4_z_mag_q, s4_r_mag_q, s4_t_mag_q;
  wcla_entry_t         s4_info_q;

  assign accept = push_i && !full_o;
  assign full_o = (credit_q == '0);

  always_comb begin
    credit_d = credit_q;
    if (accept && !credit_ret_i) begin
      credit_d = credit_q - CRED_W'(1);
    end else if (!accept && credit_ret_i) begin
      credit_d = credit_q + CRED_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_q   <= CRED_W'(QUEUE_DEPTH);
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else begin
      credit_q   <= credit_d;
      s1_valid_q <= accept;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_rdx_q          <= item_i.ray_dx;
    s1_rdy_q          <= item_i.ray_dy;
    s1_wdx_q          <= item_i.wall_dx;
    s1_wdy_q          <= item_i.wall_dy;
    s1_ex_q           <= DIFF_BITS'(item_i.wall_x) - DIFF_BITS'(item_i.ray_x);
    s1_ey_q           <= DIFF_BITS'(item_i.ray_y) - DIFF_BITS'(item_i.wall_y);
    // crossed starts as "not skipped" and is narrowed at the end
    s1_info_q.crossed <= !item_i.touches_endpoint;
    s1_info_q.loss    <= item_i.wall_loss;
    s1_info_q.last    <= item_i.last_wall;

    s2_z1_q   <= PROD_BITS'(s1_rdx_q) * PROD_BITS'(s1_wdy_q);
    s2_z2_q   <= PROD_BITS'(s1_rdy_q) * PROD_BITS'(s1_wdx_q);
    s2_r1_q   <= PROD_BITS'(s1_ey_q) * PROD_BITS'(s1_rdx_q);
    s2_r2_q   <= PROD_BITS'(s1_ex_q) * PROD_BITS'(s1_rdy_q);
    s2_t1_q   <= PROD_BITS'(s1_ex_q) * PROD_BITS'(s1_wdy_q);
    s2_t2_q   <= PROD_BITS'(s1_ey_q) * PROD_BITS'(s1_wdx_q);
    s2_info_q <= s1_info_q;

    s3_z_q    <= ACC_BITS'(s2_z1_q) - ACC_BITS'(s2_z2_q);
    s3_nr_q   <= ACC_BITS'(s2_r1_q) + ACC_BITS'(s2_r2_q);
    s3_nt_q   <= ACC_BITS'(s2_t1_q) + ACC_BITS'(s2_t2_q);
    s3_info_q <= s2_info_q;

    s4_z_neg_q <= s3_z_q[ACC_BITS-1];
    s4_r_neg_q <= s3_nr_q[ACC_BITS-1];
    s4_t_neg_q <= s3_nt_q[ACC_BITS-1];
    s4_z_nz_q  <= (s3_z_q != '0);
    s4_r_nz_q  <= (s3_nr_q != '0);
    s4_t_nz_q  <= (s3_nt_q != '0);
    s4_z_mag_q <= s3_z_q[ACC_BITS-1] ? ACC_BITS'(-s3_z_q) : ACC_BITS'(s3_z_q);
    s4_r_mag_q <= s3_nr_q[ACC_BITS-1] ? ACC_BITS'(-s3_nr_q) : ACC_BITS'(s3_nr_q);
    s4_t_mag_q <= s3_nt_q[ACC_BITS-1] ? ACC_BITS'(-s3_nt_q) : ACC_BITS'(s3_nt_q);
    s4_info_q  <= s3_info_q;
  end

  // both ratios strictly inside (0,1): same sign as z, nonzero, smaller magnitude
  always_comb begin
    entry_o         = s4_info_q;
    entry_o.crossed = s4_info_q.crossed && s4_z_nz_q && s4_r_nz_q && s4_t_nz_q
                      && (s4_r_neg_q == s4_z_neg_q) && (s4_t_neg_q == s4_z_neg_q)
                      && (s4_r_mag_q < s4_z_mag_q) && (s4_t_mag_q < s4_z_mag_q);
  end

  assign entry_valid_o = s4_valid_q;

endmodule

FILE: rtl/wcla_queue.sv
// Small register queue between the front pipeline and the accumulator.
`timescale 1ns / 1ps
module wcla_queue #(
  parameter int DEPTH = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  wcla_pkg::wcla_entry_t entry_i,
  input  logic                  pop_i,
  output wcla_pkg::wcla_entry_t entry_o,
  output logic                  empty_o,
  output logic                  full_o
);
  import wcla_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  wcla_entry_t      slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign entry_o = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (!do_push && do_pop) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

FILE: rtl/wcla_back.sv
// Back end: saturating loss accumulator and result register.
`timescale 1ns / 1ps
module wcla_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  entry_valid_i,
  input  wcla_pkg::wcla_entry_t entry_i,
  output logic                  entry_pop_o,
  output logic                  empty_o,
  input  logic                  pop_i,
  output wcla_pkg::wcla_out_t   result_o
);
  import wcla_pkg::*;

  logic [SUM_BITS-1:0] sum_q, sum_d;
  logic                ovf_q, ovf_d;
  logic                out_valid_q;
  wcla_out_t           out_q;
  logic [SUM_BITS:0]   sum_ext;
  logic [SUM_BITS-1:0] new_sum;
  logic                new_ovf;
  logic                out_taken;

  assign out_taken = pop_i && out_valid_q;
  // a last-wall entry needs a free result slot; others always drain
  assign entry_pop_o = entry_valid_i && (!entry_i.last || !out_valid_q || pop_i);

  always_comb begin
    sum_ext = {1'b0, sum_q} + (SUM_BITS + 1)'(entry_i.loss);
    new_sum = sum_q;
    new_ovf = ovf_q;
    if (entry_i.crossed) begin
      if (sum_ext[SUM_BITS]) begin
        new_sum = '1;
        new_ovf = 1'b1;
      end else begin
        new_sum = sum_ext[SUM_BITS-1:0];
      end
    end
    sum_d = sum_q;
    ovf_d = ovf_q;
    if (entry_pop_o) begin
      sum_d = entry_i.last ? '0 : new_sum;
      ovf_d = entry_i.last ? 1'b0 : new_ovf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      sum_q <= sum_d;
      ovf_q <= ovf_d;
      if (entry_pop_o && entry_i.last) begin
        out_valid_q <= 1'b1;
      end else if (out_taken) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (entry_pop_o && entry_i.last) begin
      out_q.total_loss <= new_sum[TOTAL_BITS-1:0];
      out_q.saturated  <= new_ovf;
    end
  end

  assign empty_o  = !out_valid_q;
  assign result_o = out_q;

endmodule

FILE: rtl/wall_crossing_loss_accumulator_top.sv
// Wall crossing loss accumulator: one wall per transaction, one total per ray.
// The block takes one wall per cycle while full is low. Each wall goes through a
// four-stage front pipeline (differences, six parallel products, cross product
// and numerators, sign and magnitude), is tested for a proper crossing, and
// enters a queue of QUEUE_DEPTH entries. The back end drains one queue entry
// per cycle into a saturating accumulator; on a last-wall transaction the total
// lands in a result register and the accumulator clears. Full is raised from a
// credit count of free queue slots that covers walls still in the pipeline, so
// one wall per cycle is sustained with QUEUE_DEPTH of 6 or more while the
// result side keeps up. Results stall the back end only when a total is
// waiting and another last wall arrives.
`timescale 1ns / 1ps
`include "wall_crossing_loss_accumulator_top_defines.svh"
module wall_crossing_loss_accumulator_top #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  wcla_pkg::wcla_in_t  item_i,
  output logic                empty,
  input  logic                pop,
  output wcla_pkg::wcla_out_t result_o
);
  import wcla_pkg::*;

  wcla_entry_t front_entry, queue_entry;
  logic        front_valid, queue_empty, queue_full, queue_pop;

  wcla_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .item_i       (item_i),
    .credit_ret_i (queue_pop),
    .entry_valid_o(front_valid),
    .entry_o      (front_entry)
  );

  wcla_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (front_valid),
    .entry_i(front_entry),
    .pop_i  (queue_pop),
    .entry_o(queue_entry),
    .empty_o(queue_empty),
    .full_o (queue_full)
  );

  wcla_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .entry_valid_i(!queue_empty),
    .entry_i      (queue_entry),
    .entry_pop_o  (queue_pop),
    .empty_o      (empty),
    .pop_i        (pop),
    .result_o     (result_o)
  );

  // credits must keep the queue from ever overflowing
  `WCLA_ASSERT_NEVER(a_queue_no_overflow, clk_i, rst_ni, front_valid && queue_full && !queue_pop)
  `WCLA_ASSERT_NEVER(a_pop_only_nonempty, clk_i, rst_ni, queue_pop && queue_empty)
  `WCLA_ASSERT(a_sat_total_max, clk_i, rst_ni, (!empty && result_o.saturated) |-> (&result_o.total_loss))

endmodule

FILE: verif/wall_crossing_loss_accumulator_top_tb.sv
// Testbench for the wall crossing loss accumulator: directed and random walls, scoreboard check of totals.
`timescale 1ns / 1ps

module wall_crossing_loss_accumulator_top_tb;
  import wcla_pkg::*;

  class loss_scoreboard;
    localparam longint SUM_LIMIT = (longint'(1) << SUM_BITS) - 1;

    logic [SUM_BITS-1:0] running_loss;
    logic                overflowed;
    wcla_out_t           totals_q[$];
    int                  errors;

    function new();
      running_loss = '0;
      overflowed   = 1'b0;
      errors       = 0;
    endfunction

    // n/d strictly inside (0, 1) without dividing
    function bit in_open_unit(longint num, longint den);
      longint mag_n;
      longint mag_d;
      if (num == 0 || den == 0) return 1'b0;
      if ((num < 0) != (den < 0)) return 1'b0;
      mag_n = (num < 0) ? -num : num;
      mag_d = (den < 0) ? -den : den;
      return mag_n < mag_d;
    endfunction

    function void note_wall(wcla_in_t w);
      longint rdx, rdy, wdx, wdy, ex, ey, z, nr, nt, acc;
      wcla_out_t total;
      rdx = $signed(w.ray_dx);
      rdy = $signed(w.ray_dy);
      wdx = $signed(w.wall_dx);
      wdy = $signed(w.wall_dy);
      ex  = longint'($signed(w.wall_x)) - longint'($signed(w.ray_x));
      ey  = longint'($signed(w.ray_y)) - longint'($signed(w.wall_y));
      z   = rdx * wdy - rdy * wdx;
      nr  = ey * rdx + ex * rdy;
      nt  = ex * wdy + ey * wdx;
      if (!w.touches_endpoint && z != 0 && in_open_unit(nr, z) && in_open_unit(nt, z)) begin
        acc = longint'(running_loss) + longint'(w.wall_loss);
        if (acc > SUM_LIMIT) begin
          acc = SUM_LIMIT;
          overflowed = 1'b1;
        end
        running_loss = acc[SUM_BITS-1:0];
      end
      if (w.last_wall) begin
        total.total_loss = running_loss;
        total.saturated  = overflowed;
        totals_q = {totals_q, total};
        running_loss = '0;
        overflowed   = 1'b0;
      end
    endfunction

    function void check_total(wcla_out_t got);
      wcla_out_t want;
      if (totals_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected total: expected none, actual total_loss=%0d saturated=%0b",
                 $time, got.total_loss, got.saturated);
        return;
      end
      want = totals_q.pop_front();
      if (got.total_loss !== want.total_loss) begin
        errors++;
        $display("%0t: total_loss mismatch: expected %0d, actual %0d",
                 $time, want.total_loss, got.total_loss);
      end
      if (got.saturated !== want.saturated) begin
        errors++;
        $display("%0t: saturated mismatch: expected %0b, actual %0b",
                 $time, want.saturated, got.saturated);
      end
    endfunction

    function int pending();
      return totals_q.size();
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 12;

  logic      clk_i;
  logic      rst_ni;
  logic      push;
  logic      full;
  wcla_in_t  item_i;
  logic      empty;
  logic      pop;
  wcla_out_t result_o;

  loss_scoreboard sb;
  int send_idle;
  int recv_idle;
  int hold_cycles;
  int cycle_count;

  wall_crossing_loss_accumulator_top u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push    (push),
    .full    (full),
    .item_i  (item_i),
    .empty   (empty),
    .pop     (pop),
    .result_o(result_o)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("wall_crossing_loss_accumulator_top test failed");
      $finish;
    end
  end

  function automatic wcla_in_t make_wall(int rx, int ry, int rdx, int rdy, int wx, int wy,
                                         int wdx, int wdy, int loss, bit touch, bit last);
    wcla_in_t w;
    w.ray_x            = COORD_BITS'(rx);
    w.ray_y            = COORD_BITS'(ry);
    w.ray_dx           = COORD_BITS'(rdx);
    w.ray_dy           = COORD_BITS'(rdy);
    w.wall_x           = COORD_BITS'(wx);
    w.wall_y           = COORD_BITS'(wy);
    w.wall_dx          = COORD_BITS'(wdx);
    w.wall_dy          = COORD_BITS'(wdy);
    w.wall_loss        = LOSS_BITS'(loss);
    w.touches_endpoint = touch;
    w.last_wall        = last;
    return w;
  endfunction

  function automatic int spread(int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_wall(wcla_in_t w);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push   <= 1'b1;
    item_i <= w;
    do @(posedge clk_i); while (full);
    sb.note_wall(w);
    @(negedge clk_i);
  endtask

  task automatic drain();
    push <= 1'b0;
    @(negedge clk_i);
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  task automatic run_directed();
    // horizontal ray from (0,0) to (160,0)
    send_wall(make_wall(0, 0, 160, 0, 80, -80, 0, 160, 100, 0, 0));
    send_wall(make_wall(0, 0, 160, 0, 0, 16, 160, 0, 5000, 0, 0));     // parallel
    send_wall(make_wall(0, 0, 160, 0, 40, 0, 40, 0, 5000, 0, 0));      // collinear overlap
    send_wall(make_wall(0, 0, 160, 0, 80, 0, 0, 160, 5000, 0, 0));     // wall starts on ray
    send_wall(make_wall(0, 0, 160, 0, 80, -160, 0, 160, 5000, 0, 0)); // wall ends on ray
    send_wall(make_wall(0, 0, 160, 0, 160, -80, 0, 160, 5000, 0, 0)); // ray target on wall
    send_wall(make_wall(0, 0, 160, 0, 0, -80, 0, 160, 5000, 0, 0));   // ray origin on wall
    send_wall(make_wall(0, 0, 160, 0, 80, -80, 0, 160, 5000, 1, 1));  // skipped, still emits
    send_wall(make_wall(50, 50, 0, 0, 0, 0, 100, 100, 9, 0, 0));      // zero-length ray
    send_wall(make_wall(0, 0, 160, 0, 80, 0, 0, 0, 9, 0, 0));          // zero-length wall
    send_wall(make_wall(0, 0, 160, 0, 80, -80, 0, 160, 0, 0, 0));
    send_wall(make_wall(0, 0, 160, 0, 80, -80, 0, 160, 65535, 0, 1));
    send_wall(make_wall(-32768, 0, 32767, 0, -16384, -16384, 0, 32767, 65535, 0, 0));
    send_wall(make_wall(32767, 0, -32768, 0, 0, -100, 0, 200, 65535, 0, 0));
    send_wall(make_wall(-32768, -32768, 32767, 32767, 32767, -32768, -32768, 32767,
                        65535, 0, 1));
    send_wall(make_wall(32767, 32767, -32768, -32768, -32768, 32767, 32767, -32768,
                        65535, 0, 0));
    send_wall(make_wall(0, 0, 160, 0, 80, 80, 0, -160, 1234, 0, 0));   // negative cross product
    send_wall(make_wall(160, 0, -160, 0, 80, -80, 0, 160, 4321, 0, 1));
    send_wall(make_wall(0, 0, 160, 0, 80, -80, 0, 160, 777, 1, 1));   // empty ray
  endtask

  task automatic send_crossing(int rx, int ry, int rdx, int rdy, int loss, bit touch, bit last);
    int f, g, px, py, wdx, wdy;
    f   = $urandom_range(1, 15);
    g   = $urandom_range(1, 15);
    px  = rx + (rdx * f) / 16;
    py  = ry + (rdy * f) / 16;
    wdx = spread(8000);
    wdy = spread(8000);
    send_wall(make_wall(rx, ry, rdx, rdy, px - (wdx * g) / 16, py - (wdy * g) / 16,
                        wdx, wdy, loss, touch, last));
  endtask

  task automatic run_rays(int budget);
    int sent, n, kind, loss, rx, ry, rdx, rdy;
    bit touch, last;
    sent = 0;
    while (sent < budget) begin
      rx  = spread(8000);
      ry  = spread(8000);
      rdx = spread(8000);
      rdy = spread(8000);
      n   = ($urandom_range(9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
        kind  = $urandom_range(99);
        loss  = ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(65535);
        touch = ($urandom_range(19) == 0);
        last  = (i == n - 1);
        if (kind < 65) begin
          send_crossing(rx, ry, rdx, rdy, loss, touch, last);
        end else if (kind < 75) begin
          send_wall(make_wall(rx, ry, rdx, rdy, rx + spread(1000), ry + spread(1000),
                              -rdx, -rdy, loss, touch, last));
        end else if (kind < 85) begin
          // wall anchored at the ray origin or target
          if ($urandom_range(1)) begin
            send_wall(make_wall(rx, ry, rdx, rdy, rx, ry, spread(8000), spread(8000),
                                loss, $urandom_range(3) != 0, last));
          end else begin
            send_wall(make_wall(rx, ry, rdx, rdy, rx + rdx, ry + rdy, spread(8000),
                                spread(8000), loss, $urandom_range(3) != 0, last));
          end
        end else begin
          send_wall(make_wall($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom, $urandom, 1'($urandom_range(1)),
                              1'($urandom_range(1))));
        end
      end
      sent += n;
    end
  endtask

  // enough high-loss crossings to push the sum past its maximum
  task automatic run_saturating_ray();
    int rx, ry, rdx, rdy;
    rx  = spread(4000);
    ry  = spread(4000);
    rdx = $urandom_range(2000, 8000);
    rdy = spread(8000);
    for (int i = 0; i < 270; i++) begin
      send_crossing(rx, ry, rdx, rdy, $urandom_range(16'hff00, 16'hffff), 1'b0, i == 269);
    end
  endtask

  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) sb.check_total(result_o);
  end

  initial begin
    sb          = new();
    cycle_count = 0;
    hold_cycles = 0;
    send_idle   = 29;
    recv_idle   = 86;
    rst_ni      = 1'b0;
    push        = 1'b0;
    item_i      = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    run_directed();
    run_rays(220);
    drain();

    send_idle = 86;
    recv_idle = 29;
    run_rays(220);
    drain();

    send_idle   = 0;
    recv_idle   = 0;
    hold_cycles = 400;
    run_rays(130);
    run_saturating_ray();

    push <= 1'b0;
    @(negedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (sb.pending() != 0) begin
      sb.errors++;
      $display("%0t: totals still outstanding: expected 0, actual %0d", $time, sb.pending());
    end
    if (sb.errors == 0) begin
      $display("wall_crossing_loss_accumulator_top test passed");
    end else begin
      $display("wall_crossing_loss_accumulator_top test failed");
    end
    $finish;
  end

endmodule
